FILE: rtl/smf_pkg.sv
package smf_pkg;

  localparam int SPAN_W  = 5;
  localparam int REACH_W = 8;

  typedef enum logic {
    CFG_WINDOW_SPAN = 1'b0,
    CFG_RIGHT_REACH = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_START,
    ST_READ,
    ST_CMP,
    ST_EVAL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic close;
    logic start;
    logic cmp;
    logic eval;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic n_zero;
    logic j_end;
    logic i_end;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/smf_ctrl.sv
module smf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  smf_pkg::sts_t sts,
  output smf_pkg::cmd_t cmd
);

  smf_pkg::state_t state;
  smf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      smf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = smf_pkg::ST_CHECK;
        end
      end
      smf_pkg::ST_CHECK: begin
        if (sts.more) begin
          cmd.setup  = 1'b1;
          state_next = smf_pkg::ST_START;
        end else begin
          cmd.close  = 1'b1;
          state_next = smf_pkg::ST_IDLE;
        end
      end
      smf_pkg::ST_START: begin
        if (sts.n_zero) begin
          state_next = smf_pkg::ST_FINISH;
        end else begin
          cmd.start  = 1'b1;
          state_next = smf_pkg::ST_READ;
        end
      end
      smf_pkg::ST_READ: begin
        state_next = smf_pkg::ST_CMP;
      end
      smf_pkg::ST_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = sts.j_end ? smf_pkg::ST_EVAL : smf_pkg::ST_READ;
      end
      smf_pkg::ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.i_end ? smf_pkg::ST_FINISH : smf_pkg::ST_READ;
      end
      smf_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = smf_pkg::ST_CHECK;
        end
      end
      default: state_next = smf_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/smf_dp.sv
module smf_dp #(
  parameter int MAX_REACH   = 15,
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [smf_pkg::SPAN_W-1:0]        cfg_data,
  input  logic signed [VALUE_WIDTH-1:0]     bin_value,
  input  logic                              last_bin,
  output logic signed [VALUE_WIDTH-1:0]     filtered_value,
  output logic                              last_out,
  output logic                              out_valid,
  input  logic                              out_stall,
  input  smf_pkg::cmd_t                     cmd,
  output smf_pkg::sts_t                     sts
);

  localparam int D   = 2 * MAX_REACH + 1;
  localparam int AW  = $clog2(D);
  localparam int NW  = $clog2(D + 1);
  localparam int OW  = $clog2(MAX_REACH + 2);
  localparam int KW  = COUNT_WIDTH + 8;
  localparam int RW  = smf_pkg::REACH_W;

  logic [smf_pkg::SPAN_W-1:0] window_span;
  logic [smf_pkg::SPAN_W-1:0] right_reach;

  logic signed [VALUE_WIDTH-1:0] mem [D];
  logic signed [VALUE_WIDTH-1:0] rd_i;
  logic signed [VALUE_WIDTH-1:0] rd_j;
  logic [AW-1:0] wptr;

  logic [COUNT_WIDTH-1:0] bins_seen;
  logic [COUNT_WIDTH-1:0] bins_emitted;
  logic [OW-1:0]          n_out;
  logic                   last_r;

  logic signed [KW-1:0] k_lo;
  logic signed [KW-1:0] k_hi;
  logic signed [KW-1:0] k_i;
  logic signed [KW-1:0] k_j;
  logic [NW-1:0] n_reg;
  logic [NW-1:0] lt;
  logic [NW-1:0] le;
  logic [NW-1:0] ta;
  logic [NW-1:0] tb;
  logic signed [VALUE_WIDTH-1:0] ma;
  logic signed [VALUE_WIDTH-1:0] mb;

  logic signed [RW-1:0] left_c;
  logic signed [RW-1:0] right_c;
  logic signed [RW-1:0] left_s;
  logic signed [RW-1:0] right_s;
  logic [COUNT_WIDTH-1:0] pending;
  logic signed [KW-1:0] p_s;
  logic signed [KW-1:0] lo_c;
  logic signed [KW-1:0] hi_c;
  logic signed [KW-1:0] diff_c;
  logic [NW-1:0] n_c;
  logic [AW-1:0] addr_i;
  logic [AW-1:0] addr_j;
  logic signed [VALUE_WIDTH:0] pair_sum;

  // reaches from the two registers
  always_comb begin
    if (right_reach == {smf_pkg::SPAN_W{1'b1}}) begin
      right_c = RW'({1'b0, window_span[smf_pkg::SPAN_W-1:1]});
      left_c  = window_span[0] ? right_c : right_c - RW'(1);
    end else begin
      left_c  = RW'({1'b0, window_span});
      right_c = right_reach[smf_pkg::SPAN_W-1] ? '0 : RW'({1'b0, right_reach});
    end
    left_s  = (left_c > RW'(MAX_REACH)) ? RW'(MAX_REACH) : left_c;
    right_s = (right_c > RW'(MAX_REACH)) ? RW'(MAX_REACH) : right_c;
  end

  assign pending = bins_seen - bins_emitted;
  assign p_s     = KW'({1'b0, pending});

  // window bounds in offsets relative to the center bin
  always_comb begin
    lo_c = -KW'(left_s);
    if (-$signed(KW'({1'b0, bins_emitted})) > lo_c)
      lo_c = -$signed(KW'({1'b0, bins_emitted}));
    if (p_s - KW'(D) > lo_c) lo_c = p_s - KW'(D);
    hi_c = KW'(right_s);
    if (p_s - KW'(1) < hi_c) hi_c = p_s - KW'(1);
    diff_c = hi_c - lo_c;
    n_c = (diff_c < 0) ? '0 : NW'(diff_c + KW'(1));
  end

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] wp,
                                         input logic signed [KW-1:0] p,
                                         input logic signed [KW-1:0] k);
    logic [AW-1:0] off;
    logic [AW:0]   idx;
    off = AW'(p - KW'(1) - k);
    idx = {1'b0, wp} + (AW+1)'(D - 1) - {1'b0, off};
    if (idx >= (AW+1)'(D)) idx = idx - (AW+1)'(D);
    return idx[AW-1:0];
  endfunction

  assign addr_i = slot(wptr, p_s, k_i);
  assign addr_j = slot(wptr, p_s, k_j);

  always_ff @(posedge clk) begin
    if (cmd.load) mem[wptr] <= bin_value;
    rd_i <= mem[addr_i];
    rd_j <= mem[addr_j];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_span <= smf_pkg::SPAN_W'(3);
      right_reach <= '1;
    end else if (cfg_write) begin
      unique case (smf_pkg::cfg_idx_t'(cfg_index))
        smf_pkg::CFG_WINDOW_SPAN: window_span <= cfg_data;
        smf_pkg::CFG_RIGHT_REACH: right_reach <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pair_sum = {ma[VALUE_WIDTH-1], ma} + {mb[VALUE_WIDTH-1], mb};

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr         <= '0;
      bins_seen    <= '0;
      bins_emitted <= '0;
      n_out        <= '0;
      last_r       <= 1'b0;
      out_valid    <= 1'b0;
      lt           <= '0;
      le           <= '0;
      n_reg        <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.load) begin
        wptr      <= (wptr == AW'(D - 1)) ? '0 : wptr + AW'(1);
        bins_seen <= bins_seen + COUNT_WIDTH'(1);
        last_r    <= last_bin;
        n_out     <= '0;
      end
      if (cmd.close && last_r) begin
        bins_seen    <= '0;
        bins_emitted <= '0;
      end
      if (cmd.setup) begin
        k_lo  <= lo_c;
        k_hi  <= hi_c;
        n_reg <= n_c;
        ta    <= (n_c - NW'(1)) >> 1;
        tb    <= n_c >> 1;
      end
      if (cmd.start) begin
        k_i <= k_lo;
        k_j <= k_lo;
        lt  <= '0;
        le  <= '0;
      end
      if (cmd.cmp) begin
        if (rd_j < rd_i)  lt <= lt + NW'(1);
        if (rd_j <= rd_i) le <= le + NW'(1);
        if (k_j != k_hi)  k_j <= k_j + KW'(1);
      end
      if (cmd.eval) begin
        if (lt <= ta && ta < le) ma <= rd_i;
        if (lt <= tb && tb < le) mb <= rd_i;
        k_i <= k_i + KW'(1);
        k_j <= k_lo;
        lt  <= '0;
        le  <= '0;
      end
      if (cmd.finish) begin
        out_valid      <= 1'b1;
        filtered_value <= (n_reg == '0) ? '0 : pair_sum[VALUE_WIDTH:1];
        last_out       <= last_r && (pending == COUNT_WIDTH'(1) ||
                                     n_out == OW'(MAX_REACH));
        bins_emitted   <= bins_emitted + COUNT_WIDTH'(1);
        n_out          <= n_out + OW'(1);
      end
    end
  end

  always_comb begin
    sts.more     = (n_out < OW'(MAX_REACH + 1)) &&
                   (last_r ? (pending != '0)
                           : ({7'b0, pending} > (COUNT_WIDTH+7)'(right_s[RW-2:0])));
    sts.n_zero   = (n_reg == '0);
    sts.j_end    = (k_j == k_hi);
    sts.i_end    = (k_i == k_hi);
    sts.out_free = !out_valid || !out_stall;
  end

  a_rank_order: assert property (@(posedge clk) disable iff (rst) le >= lt)
    else $error("less-than count exceeds less-or-equal count");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) n_reg <= NW'(D))
    else $error("window count beyond store depth");
  a_wptr_bound: assert property (@(posedge clk) disable iff (rst) wptr < AW'(D))
    else $error("write pointer out of range");
  a_finish_out: assert property (@(posedge clk) disable iff (rst) cmd.finish |=> out_valid)
    else $error("finished result not presented");

endmodule

FILE: rtl/sliding_median_filter_core.sv
// Sequence: a request is taken in IDLE; each result then passes CHECK, START,
//   the rank-counting scan over a two-read-port window store (window count
//   at most 2*MAX_REACH+1; READ, CMP per pair, EVAL per member), and FINISH,
//   which waits out output stalls. Throughput: one request at a time; the next
//   request is taken once all of its results have been handed to the output register.
// Reset (rst, synchronous): counters and handshake clear, registers return to
//   window_span = 3 and right_reach = -1; the window store is not cleared.
module sliding_median_filter_core #(
  parameter int MAX_REACH   = 15,
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [4:0]                    cfg_data,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] bin_value,
  input  logic                          last_bin,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] filtered_value,
  output logic                          last_out
);

  smf_pkg::cmd_t cmd;
  smf_pkg::sts_t sts;

  // Sequencer: take a request, then walk each pending result through
  // range setup, the rank scan and the hand-off to the output register.
  smf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Window store, counters, rank counters and the output register.
  // The median is found by counting, for each window member, how many
  // members lie below it; the two middle ranks are averaged (floored).
  smf_dp #(
    .MAX_REACH   (MAX_REACH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .bin_value      (bin_value),
    .last_bin       (last_bin),
    .filtered_value (filtered_value),
    .last_out       (last_out),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule
